FILE: rtl/core/tmis_pkg.sv
// ----------------------------------------------------------------------------
// tmis_pkg
// Shared types, constants and helpers of the magnitude index select core.
// ----------------------------------------------------------------------------
package tmis_pkg;

  localparam int unsigned WeightW    = 32;
  localparam int unsigned MagW       = 31;
  localparam int unsigned ValueW     = 11;
  localparam int unsigned TopW       = 6;
  localparam int unsigned OutDataW   = 16;

  localparam logic [TopW-1:0]    TopCountReset = 6'd50;
  localparam logic [MagW-1:0]    MagMax        = 31'h7FFF_FFFF;
  localparam logic [WeightW-1:0] WeightMinNeg  = 32'h8000_0000;

  localparam logic KindCount = 1'b0;
  localparam logic KindIndex = 1'b1;

  // one result on its way from the sequencer to the output register
  typedef struct packed {
    logic              kind;
    logic [ValueW-1:0] value;
    logic              last;
  } res_t;

  // magnitude of a two's complement weight, most negative value saturates
  function automatic logic [MagW-1:0] mag_of(input logic [WeightW-1:0] raw);
    logic [WeightW-1:0] neg;
    neg = (~raw) + 32'd1;
    if (raw == WeightMinNeg) begin
      return MagMax;
    end else if (raw[WeightW-1]) begin
      return neg[MagW-1:0];
    end else begin
      return raw[MagW-1:0];
    end
  endfunction

endpackage

FILE: rtl/core/tmis_mag_ram.sv
// ----------------------------------------------------------------------------
// tmis_mag_ram
// Magnitude store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tmis_mag_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [tmis_pkg::MagW-1:0]  wdata_i,
  input  logic                       re_i,
  input  logic [AddrW-1:0]           raddr_i,
  output logic [tmis_pkg::MagW-1:0]  rdata_o
);

  logic [tmis_pkg::MagW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: rtl/core/tmis_ctrl.sv
// ----------------------------------------------------------------------------
// tmis_ctrl
// Load and selection sequencer: stores magnitudes, counts nonzero weights,
// then runs one argmax scan over the store per reported index.
// ----------------------------------------------------------------------------
module tmis_ctrl #(
  parameter int unsigned MaxLength = 1024,
  parameter int unsigned MaxTop    = 50,
  parameter int unsigned AddrW     = 10,
  parameter int unsigned LenW      = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tmis_pkg::WeightW-1:0]  weight_i,
  input  logic                          last_weight_i,
  input  logic [tmis_pkg::TopW-1:0]     top_count_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output tmis_pkg::res_t                res_o,
  output logic                          mem_we_o,
  output logic [AddrW-1:0]              mem_waddr_o,
  output logic [tmis_pkg::MagW-1:0]     mem_wdata_o,
  output logic                          mem_re_o,
  output logic [AddrW-1:0]              mem_raddr_o,
  input  logic [tmis_pkg::MagW-1:0]     mem_rdata_i
);

  localparam logic [1:0] StLoad = 2'd0;
  localparam logic [1:0] StCnt  = 2'd1;
  localparam logic [1:0] StScan = 2'd2;
  localparam logic [1:0] StPick = 2'd3;

  localparam logic [LenW-1:0]           LenMax = LenW'(MaxLength);
  localparam logic [tmis_pkg::TopW-1:0] TopMax = tmis_pkg::TopW'(MaxTop);

  logic [1:0]                    state_q, state_d;
  logic [LenW-1:0]               len_q, len_d;
  logic [LenW-1:0]               nz_q, nz_d;
  logic [tmis_pkg::TopW-1:0]     picks_q, picks_d;
  logic [LenW-1:0]               rd_cnt_q, rd_cnt_d;
  logic                          rd_valid_q, rd_valid_d;
  logic                          rd_last_q, rd_last_d;
  logic [AddrW-1:0]              rd_idx_q, rd_idx_d;
  logic [tmis_pkg::MagW-1:0]     best_mag_q, best_mag_d;
  logic [AddrW-1:0]              best_idx_q, best_idx_d;

  logic in_fire;
  logic issue;
  logic take;

  assign in_ready_o = (state_q == StLoad);
  assign in_fire    = in_valid_i && in_ready_o;
  assign issue      = (state_q == StScan) && (rd_cnt_q < len_q);
  assign take       = (rd_idx_q == '0) || (mem_rdata_i > best_mag_q);

  assign mem_re_o    = issue;
  assign mem_raddr_o = rd_cnt_q[AddrW-1:0];

  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = len_q[AddrW-1:0];
    mem_wdata_o = tmis_pkg::mag_of(weight_i);
    res_valid_o = 1'b0;
    res_o.kind  = tmis_pkg::KindCount;
    res_o.value = tmis_pkg::ValueW'(nz_q);
    res_o.last  = (picks_q == '0);

    state_d    = state_q;
    len_d      = len_q;
    nz_d       = nz_q;
    picks_d    = picks_q;
    rd_cnt_d   = rd_cnt_q;
    rd_valid_d = issue;
    rd_last_d  = (LenW'(rd_cnt_q + 1'b1) == len_q);
    rd_idx_d   = rd_cnt_q[AddrW-1:0];
    best_mag_d = best_mag_q;
    best_idx_d = best_idx_q;

    if (issue) begin
      rd_cnt_d = LenW'(rd_cnt_q + 1'b1);
    end

    unique case (state_q)
      StLoad: begin
        if (in_fire) begin
          if (len_q < LenMax) begin
            mem_we_o = 1'b1;
            len_d    = LenW'(len_q + 1'b1);
            if (weight_i != '0) begin
              nz_d = LenW'(nz_q + 1'b1);
            end
          end
          if (last_weight_i) begin
            picks_d = (top_count_i > TopMax) ? TopMax : top_count_i;
            state_d = StCnt;
          end
        end
      end
      StCnt: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          rd_cnt_d = '0;
          if (picks_q == '0) begin
            len_d   = '0;
            nz_d    = '0;
            state_d = StLoad;
          end else begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (rd_valid_q) begin
          if (take) begin
            best_mag_d = mem_rdata_i;
            best_idx_d = rd_idx_q;
          end
          if (rd_last_q) begin
            state_d = StPick;
          end
        end
      end
      StPick: begin
        res_valid_o = 1'b1;
        res_o.kind  = tmis_pkg::KindIndex;
        res_o.value = tmis_pkg::ValueW'(best_idx_q);
        res_o.last  = (picks_q == tmis_pkg::TopW'(1));
        mem_waddr_o = best_idx_q;
        mem_wdata_o = '0;
        if (res_ready_i) begin
          // zero the reported entry before the next pass reads it
          mem_we_o = 1'b1;
          picks_d  = picks_q - 1'b1;
          rd_cnt_d = '0;
          if (picks_q == tmis_pkg::TopW'(1)) begin
            len_d   = '0;
            nz_d    = '0;
            state_d = StLoad;
          end else begin
            state_d = StScan;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      len_q      <= '0;
      nz_q       <= '0;
      picks_q    <= '0;
      rd_cnt_q   <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      len_q      <= len_d;
      nz_q       <= nz_d;
      picks_q    <= picks_d;
      rd_cnt_q   <= rd_cnt_d;
      rd_valid_q <= rd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_last_q  <= rd_last_d;
    rd_idx_q   <= rd_idx_d;
    best_mag_q <= best_mag_d;
    best_idx_q <= best_idx_d;
  end

endmodule

FILE: rtl/core/top_magnitude_index_select_core.sv
// results: the last weight moves the sequencer to its count state; the count result
//   then passes the output register; each index follows one argmax pass over the store
// throughput: one weight per cycle while loading, none while a run is reported;
//   selection is bounded by the single read port of the store
// reset: control and counters clear, top_count returns to 50, store is not cleared
// ----------------------------------------------------------------------------
// top_magnitude_index_select_core
// Loads a weight vector and reports its nonzero count and the indices of the
// largest magnitudes, one argmax pass over the store per index.
// ----------------------------------------------------------------------------
module top_magnitude_index_select_core #(
  parameter int unsigned MAX_LENGTH = 1024,
  parameter int unsigned MAX_TOP    = 50
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [tmis_pkg::WeightW-1:0]    s_axis_tdata_i,   // [31:0] weight
  input  logic                            s_axis_tlast_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [tmis_pkg::OutDataW-1:0]   m_axis_tdata_o,   // [10:0] count_or_index
  output logic                            m_axis_tuser_o,   // [0] kind
  output logic                            m_axis_tlast_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tmis_pkg::TopW-1:0]       cfg_data_i
);

  localparam int unsigned AddrW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int unsigned LenW  = $clog2(MAX_LENGTH + 1);

  logic [tmis_pkg::TopW-1:0] top_count_q;
  logic                      out_valid_q;
  tmis_pkg::res_t            out_res_q;
  tmis_pkg::res_t            res;
  logic                      res_valid;
  logic                      slot_free;

  logic                      mem_we;
  logic [AddrW-1:0]          mem_waddr;
  logic [tmis_pkg::MagW-1:0] mem_wdata;
  logic                      mem_re;
  logic [AddrW-1:0]          mem_raddr;
  logic [tmis_pkg::MagW-1:0] mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_count_q <= tmis_pkg::TopCountReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      top_count_q <= cfg_data_i;
    end
  end

  // output register decouples the sequencer from the result sink
  assign slot_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = tmis_pkg::OutDataW'(out_res_q.value);
  assign m_axis_tuser_o  = out_res_q.kind;
  assign m_axis_tlast_o  = out_res_q.last;

  tmis_ctrl #(
    .MaxLength (MAX_LENGTH),
    .MaxTop    (MAX_TOP),
    .AddrW     (AddrW),
    .LenW      (LenW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .weight_i      (s_axis_tdata_i),
    .last_weight_i (s_axis_tlast_i),
    .top_count_i   (top_count_q),
    .res_valid_o   (res_valid),
    .res_ready_i   (slot_free),
    .res_o         (res),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  tmis_mag_ram #(
    .Depth (MAX_LENGTH),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

FILE: rtl/core/tmis_checker.sv
// ----------------------------------------------------------------------------
// tmis_checker
// Port-level checks of the magnitude index select core, bound to the top.
// ----------------------------------------------------------------------------
module tmis_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  logic       in_last_fire;
  logic       cnt_fire;
  logic [1:0] runs_q;

  assign in_last_fire = s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i;
  assign cnt_fire     = m_axis_tvalid_o && m_axis_tready_i
                        && (m_axis_tuser_o == tmis_pkg::KindCount);

  // runs whose count result is still owed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      runs_q <= '0;
    end else begin
      runs_q <= runs_q + {1'b0, in_last_fire} - {1'b0, cnt_fire};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("result transaction dropped or changed while stalled");

  a_stall_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_last_fire |=> !s_axis_tready_o)
    else $error("weight taken while selection runs");

  a_count_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_fire |-> runs_q != 2'd0)
    else $error("count result without a finished vector");

  // one count may wait in the output register while the next one is pending
  a_two_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    runs_q != 2'd3)
    else $error("more than two count results owed");

endmodule

bind top_magnitude_index_select_core tmis_checker u_tmis_checker (.*);
